### design/hpcr_pkg.sv
package hpcr_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned OccW       = $clog2(MaxEntries + 1);
  localparam int unsigned KeyW       = 64;
  localparam int unsigned HintW      = 17;
  localparam int unsigned PriW       = 63;
  localparam int unsigned CntW       = 40;
  localparam int unsigned CapW       = 7;
  localparam int unsigned RamW       = KeyW + PriW;

  localparam logic [PriW-1:0] PriMax = {PriW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CapW-1:0] CapReset = CapW'(MaxEntries);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch input, clear scan results
    logic rd_en;     // issue a RAM read at the scan index
    logic scan_en;   // compare the registered read data
    logic decide;    // resolve hit/miss/evict, write RAM, form result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_idx;  // scan index at final slot
  } sts_t;

  // Priority: 4^(hint+5) + counter, saturated; hint -1 gives max.
  function automatic logic [PriW-1:0] make_priority(
    input logic signed [HintW-1:0] hint,
    input logic [CntW-1:0]         cnt
  );
    logic signed [HintW:0] e;
    logic [PriW:0]         p;
    e = {hint[HintW-1], hint} + (HintW+1)'(5);
    p = '0;
    if (hint == -(HintW'(1))) begin
      make_priority = PriMax;
    end else if (e < 0) begin
      make_priority = PriW'(cnt);
    end else if (e > 31) begin
      make_priority = PriMax;
    end else begin
      p = ((PriW+1)'(1) << (2 * e[4:0])) + (PriW+1)'(cnt);
      make_priority = p[PriW] ? PriMax : p[PriW-1:0];
    end
  endfunction

endpackage

### design/hpcr_if.sv
interface hpcr_in_if;
  logic                         valid;
  logic                         ready;
  logic [hpcr_pkg::KeyW-1:0]    key;
  logic signed [hpcr_pkg::HintW-1:0] hint;
  modport source  (output valid, key, hint, input ready);
  modport sink    (input valid, key, hint, output ready);
  modport monitor (input valid, ready, key, hint);
endinterface

interface hpcr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      evicted_valid;
  logic [hpcr_pkg::KeyW-1:0] victim_key;
  modport source  (output valid, hit, evicted_valid, victim_key, input ready);
  modport sink    (input valid, hit, evicted_valid, victim_key, output ready);
  modport monitor (input valid, ready, hit, evicted_valid, victim_key);
endinterface

### design/hint_priority_cache_replacement_top.sv
// An accepted input transaction starts a sweep of the entry RAM over all 64 slots,
// one slot per cycle, then a compare of the last read, an empty DECIDE state and an
// OUT state that resolves the access, writes back and fills the result register. One
// access at a time; a result left waiting holds the next access before its write-back.
// Reset: asynchronous active low; clears valid bits, occupancy, counter and sets
// capacity to 64. Entry RAM needs no clearing.
module hint_priority_cache_replacement_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hpcr_pkg::CapW-1:0]      cfg_wdata_i,
  hpcr_in_if.sink                        in_if,
  hpcr_out_if.source                     out_if
);
  hpcr_pkg::cmd_t cmd;
  hpcr_pkg::sts_t sts;

  hpcr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  hpcr_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_wdata_i,
    .key_i(in_if.key), .hint_i(in_if.hint),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .hit_o(out_if.hit), .evicted_valid_o(out_if.evicted_valid),
    .victim_key_o(out_if.victim_key)
  );
endmodule

### design/hpcr_ram.sv
module hpcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### design/hpcr_ctrl.sv
module hpcr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  hpcr_pkg::sts_t        sts_i,
  output hpcr_pkg::cmd_t        cmd_o
);
  hpcr_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hpcr_pkg::ST_IDLE:   if (in_valid_i) state_d = hpcr_pkg::ST_SCAN;
      hpcr_pkg::ST_SCAN:   if (sts_i.last_idx) state_d = hpcr_pkg::ST_LAST;
      hpcr_pkg::ST_LAST:   state_d = hpcr_pkg::ST_DECIDE;
      hpcr_pkg::ST_DECIDE: state_d = hpcr_pkg::ST_OUT;
      hpcr_pkg::ST_OUT:    if (!out_valid_i || out_ready_i) state_d = hpcr_pkg::ST_IDLE;
      default:             state_d = hpcr_pkg::ST_IDLE;
    endcase
  end

  // outputs; the result register may still hold the previous result while scanning
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hpcr_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      hpcr_pkg::ST_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.scan_en = 1'b1;
      end
      hpcr_pkg::ST_LAST:   cmd_o.scan_en = 1'b1;
      hpcr_pkg::ST_DECIDE: ;
      hpcr_pkg::ST_OUT:    cmd_o.decide = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpcr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == hpcr_pkg::ST_IDLE) else $error("ready outside idle");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == hpcr_pkg::ST_SCAN) else $error("start without scan");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.decide, cmd_o.scan_en})) else $error("command overlap");
`endif
endmodule

### design/hpcr_dp.sv
module hpcr_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hpcr_pkg::cmd_t                   cmd_i,
  output hpcr_pkg::sts_t                   sts_o,
  input  logic                             cfg_we_i,
  input  logic [hpcr_pkg::CapW-1:0]        cfg_wdata_i,
  input  logic [hpcr_pkg::KeyW-1:0]        key_i,
  input  logic signed [hpcr_pkg::HintW-1:0] hint_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             hit_o,
  output logic                             evicted_valid_o,
  output logic [hpcr_pkg::KeyW-1:0]        victim_key_o
);
  localparam int unsigned IW = hpcr_pkg::IdxW;
  localparam int unsigned KW = hpcr_pkg::KeyW;
  localparam int unsigned PW = hpcr_pkg::PriW;

  logic [hpcr_pkg::CapW-1:0] cap_q;
  logic [hpcr_pkg::CntW-1:0] cnt_q;
  logic [hpcr_pkg::OccW-1:0] occ_q;
  logic [hpcr_pkg::MaxEntries-1:0] valid_q;
  logic [KW-1:0] key_q;
  logic [PW-1:0] pri_q;
  logic [IW-1:0] rd_idx_q, cmp_idx_q;
  logic          found_q, free_f_q, vic_f_q;
  logic [IW-1:0] found_idx_q, free_idx_q, vic_idx_q;
  logic [KW-1:0] vic_key_q;
  logic [PW-1:0] best_q;

  // entry store: key and priority side by side
  logic                 we;
  logic [IW-1:0]        waddr;
  logic [hpcr_pkg::RamW-1:0] rdata;
  logic [KW-1:0]        rkey;
  logic [PW-1:0]        rpri;

  hpcr_ram #(.Width(hpcr_pkg::RamW), .Depth(hpcr_pkg::MaxEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i({key_q, pri_q}),
    .re_i(cmd_i.rd_en), .raddr_i(rd_idx_q), .rdata_o(rdata)
  );
  assign rkey = rdata[hpcr_pkg::RamW-1:PW];
  assign rpri = rdata[PW-1:0];
  assign sts_o.last_idx = (rd_idx_q == IW'(hpcr_pkg::MaxEntries - 1));

  // decision
  logic [hpcr_pkg::OccW:0] cap_eff;
  logic evict, self_ev;
  always_comb begin
    cap_eff = (cap_q > hpcr_pkg::CapW'(hpcr_pkg::MaxEntries))
            ? (hpcr_pkg::OccW+1)'(hpcr_pkg::MaxEntries) : (hpcr_pkg::OccW+1)'(cap_q);
    evict   = !found_q && ((hpcr_pkg::OccW+1)'(occ_q) + 1'b1 > cap_eff);
    self_ev = !vic_f_q || (pri_q > best_q);
    we      = 1'b0;
    waddr   = free_idx_q;
    if (cmd_i.decide) begin
      if (found_q) begin
        we = 1'b1; waddr = found_idx_q;
      end else if (evict) begin
        we = !self_ev; waddr = vic_idx_q;
      end else begin
        we = free_f_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= hpcr_pkg::CapReset;
      cnt_q       <= '0;
      occ_q       <= '0;
      valid_q     <= '0;
      out_valid_o <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.decide) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.start) rd_idx_q <= '0;
      else if (cmd_i.rd_en && !sts_o.last_idx) rd_idx_q <= rd_idx_q + 1'b1;
      if (cmd_i.decide) begin
        if (cnt_q != hpcr_pkg::CntMax) cnt_q <= cnt_q + 1'b1;
        if (!found_q && !evict && free_f_q) begin
          valid_q[free_idx_q] <= 1'b1;
          occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q    <= key_i;
      pri_q    <= hpcr_pkg::make_priority(hint_i, cnt_q);
      found_q  <= 1'b0;
      free_f_q <= 1'b0;
      vic_f_q  <= 1'b0;
    end
    if (cmd_i.rd_en) cmp_idx_q <= rd_idx_q;
    if (cmd_i.scan_en && (cmd_i.rd_en ? rd_idx_q != '0 : 1'b1)) begin
      if (valid_q[cmp_idx_q]) begin
        if (!found_q && rkey == key_q) begin
          found_q <= 1'b1; found_idx_q <= cmp_idx_q;
        end
        if (!vic_f_q || rpri > best_q) begin
          vic_f_q <= 1'b1; vic_idx_q <= cmp_idx_q; best_q <= rpri; vic_key_q <= rkey;
        end
      end else if (!free_f_q) begin
        free_f_q <= 1'b1; free_idx_q <= cmp_idx_q;
      end
    end
    if (cmd_i.decide) begin
      hit_o           <= found_q;
      evicted_valid_o <= evict;
      victim_key_o    <= !evict ? '0 : (self_ev ? key_q : vic_key_q);
    end
  end

`ifndef SYNTHESIS
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == hpcr_pkg::OccW'($countones(valid_q))) else $error("occupancy mismatch");
  a_hit_noev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o) else $error("hit evicted");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> cnt_q != $past(cnt_q) || cnt_q == hpcr_pkg::CntMax)
    else $error("counter stuck");
`endif
endmodule

### test/hpcr_checker.sv
`timescale 1ns / 1ps

module hpcr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  hpcr_in_if.monitor  in_mon,
  hpcr_out_if.monitor out_mon,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic                      hit;
    logic                      ev_valid;
    logic [hpcr_pkg::KeyW-1:0] ev_key;
  } access_res_t;

  logic [hpcr_pkg::KeyW-1:0] slot_key [hpcr_pkg::MaxEntries];
  logic                      slot_used [hpcr_pkg::MaxEntries];
  logic [hpcr_pkg::PriW-1:0] slot_pri [hpcr_pkg::MaxEntries];
  logic [hpcr_pkg::CntW-1:0] acc_cnt;
  int unsigned               fill_level;
  int unsigned               cap_reg;
  access_res_t               expected_q[$];

  assign pending_o = expected_q.size();

  // Saturating priority for one access
  function automatic logic [hpcr_pkg::PriW-1:0] access_priority(
    input int h, input logic [hpcr_pkg::CntW-1:0] c);
    int e;
    logic [hpcr_pkg::PriW:0] s;
    e = h + 5;
    if (h == -1) return hpcr_pkg::PriMax;
    if (e < 0) return hpcr_pkg::PriW'(c);
    if (e > 31) return hpcr_pkg::PriMax;
    s = ((hpcr_pkg::PriW+1)'(1) << (2 * e)) + (hpcr_pkg::PriW+1)'(c);
    return s[hpcr_pkg::PriW] ? hpcr_pkg::PriMax : s[hpcr_pkg::PriW-1:0];
  endfunction

  // Update the mirror of the cache and return the expected result
  function automatic access_res_t lookup_and_replace(
    input logic [hpcr_pkg::KeyW-1:0] k, input logic signed [hpcr_pkg::HintW-1:0] hn);
    access_res_t r;
    logic [hpcr_pkg::PriW-1:0] p, best;
    int unsigned cap;
    int found, free_slot, victim;
    r = '0;
    p = access_priority(int'(hn), acc_cnt);
    cap = (cap_reg > hpcr_pkg::MaxEntries) ? hpcr_pkg::MaxEntries : cap_reg;
    found = -1; free_slot = -1; victim = -1; best = '0;
    for (int i = 0; i < hpcr_pkg::MaxEntries; i++) begin
      if (slot_used[i]) begin
        if (found < 0 && slot_key[i] == k) found = i;
      end else if (free_slot < 0) free_slot = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      slot_pri[found] = p;
    end else if (fill_level + 1 > cap) begin
      for (int i = 0; i < hpcr_pkg::MaxEntries; i++)
        if (slot_used[i] && (victim < 0 || slot_pri[i] > best)) begin
          victim = i;
          best = slot_pri[i];
        end
      r.ev_valid = 1'b1;
      if (victim < 0 || p > best) r.ev_key = k;
      else begin
        r.ev_key = slot_key[victim];
        slot_key[victim] = k;
        slot_pri[victim] = p;
      end
    end else if (free_slot >= 0) begin
      slot_key[free_slot] = k;
      slot_pri[free_slot] = p;
      slot_used[free_slot] = 1'b1;
      fill_level++;
    end
    if (acc_cnt != hpcr_pkg::CntMax) acc_cnt++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [hpcr_pkg::KeyW-1:0] got,
                                 input logic [hpcr_pkg::KeyW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    access_res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < hpcr_pkg::MaxEntries; i++) slot_used[i] = 1'b0;
      acc_cnt = '0;
      fill_level = 0;
      cap_reg = hpcr_pkg::MaxEntries;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result", '0, '0);
        else begin
          e = expected_q.pop_front();
          if (out_mon.hit !== e.hit)
            report_mismatch("hit", 64'(out_mon.hit), 64'(e.hit));
          if (out_mon.evicted_valid !== e.ev_valid)
            report_mismatch("evicted_valid", 64'(out_mon.evicted_valid), 64'(e.ev_valid));
          if (out_mon.victim_key !== e.ev_key)
            report_mismatch("victim_key", out_mon.victim_key, e.ev_key);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(lookup_and_replace(in_mon.key, in_mon.hint));
      if (cfg_we_i) cap_reg = 32'(cfg_wdata_i);
    end
  end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [hpcr_pkg::CapW-1:0] cfg_wdata_i = '0;
  int fail_count, pending;
  int idle_pct = 35;
  bit hold_rx = 1'b0;
  int quiet_cycles = 0;
  logic [hpcr_pkg::KeyW-1:0] key_pool [16];

  hpcr_in_if  acc_ch ();
  hpcr_out_if res_ch ();

  hint_priority_cache_replacement_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_if(acc_ch.sink), .out_if(res_ch.source)
  );

  hpcr_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_mon(acc_ch.monitor), .out_mon(res_ch.monitor),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    acc_ch.valid = 1'b0;
    acc_ch.key = '0;
    acc_ch.hint = '0;
    res_ch.ready = 1'b0;
  end

  // Result side back-pressure
  always @(negedge clk_i)
    res_ch.ready <= !hold_rx && ($urandom_range(99) >= idle_pct);

  // Watchdog on transactions
  always @(posedge clk_i) begin
    if ((acc_ch.valid && acc_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[hint_priority_cache_replacement_top] ERROR");
      $finish;
    end
  end

  // Offer one transaction; valid stays up until the next call or an idle request
  task automatic send_access(input logic [hpcr_pkg::KeyW-1:0] k,
                             input logic signed [hpcr_pkg::HintW-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      acc_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    acc_ch.valid <= 1'b1;
    acc_ch.key <= k;
    acc_ch.hint <= h;
    do @(posedge clk_i); while (!acc_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_then_idle();
    acc_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [hpcr_pkg::CapW-1:0] c);
    drain_then_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [hpcr_pkg::HintW-1:0] rand_hint();
    unique case ($urandom_range(5))
      0: return -17'sd1;
      1: return 17'(int'($urandom_range(0, 6)) - 11);
      2: return 17'($urandom_range(65535)) | 17'h10000;
      3: return 17'($urandom_range(65535));
      default: return 17'($urandom_range(30));
    endcase
  endfunction

  function automatic logic [hpcr_pkg::KeyW-1:0] rand_key();
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(15)];
    return {$urandom, $urandom};
  endfunction

  // Stimulus
  initial begin
    logic [hpcr_pkg::CapW-1:0] caps [6] = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd16};
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, hint special cases, small capacity ties
    set_capacity(7'd3);
    send_access('0, 17'sd0);
    send_access('1, -17'sd1);
    send_access(64'h5555_5555_5555_5555, 17'sh10000);
    send_access(64'hAAAA_AAAA_AAAA_AAAA, -17'sd5);
    send_access(64'h1, -17'sd6);
    send_access(64'h2, 17'sd26);
    send_access(64'h3, 17'sd27);
    send_access(64'h4, 17'sd65535);
    send_access('0, 17'sd3);
    send_access('1, 17'sd3);
    send_access(64'h7, -17'sd1);
    send_access(64'h8, 17'sd1);
    send_access(64'h8, 17'sd1);
    set_capacity(7'd1);
    send_access(64'h9, 17'sd2);
    send_access(64'hA, 17'sd2);

    // Random phases over several capacity settings
    for (int ph = 0; ph < 6; ph++) begin
      set_capacity(caps[ph]);
      for (int n = 0; n < 220; n++) begin
        idle_pct = (ph == 2) ? 0 : 35;
        if (ph == 1 && n == 50) begin
          fork
            begin
              hold_rx = 1'b1;
              repeat (600) @(negedge clk_i);
              hold_rx = 1'b0;
            end
          join_none
        end
        if (ph == 4 && n == 100) begin
          acc_ch.valid <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        send_access(rand_key(), rand_hint());
      end
    end

    drain_then_idle();
    if (fail_count == 0) $display("[hint_priority_cache_replacement_top] OK");
    else $display("[hint_priority_cache_replacement_top] ERROR");
    $finish;
  end
endmodule
